// File: rtl/slrg_pkg.sv
`timescale 1ns / 1ps
// slrg_pkg: constants, types and the modular reduction of the shuffled lehmer generator
// no dependencies; used by shuffled_lehmer_random_generator_core
package slrg_pkg;

  // shuffle table size, a power of two between 8 and 64
  localparam int TableEntries = 32;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int WarmupExtra  = 8;
  localparam int SeedSteps    = TableEntries + WarmupExtra;
  localparam int CntW         = $clog2(SeedSteps);

  localparam int WordW = 31;
  localparam int MultW = 15;
  localparam int ProdW = WordW + MultW;

  localparam logic [MultW-1:0] LehmerMult = 15'd16807;
  localparam logic [WordW-1:0] LehmerMod  = 31'h7FFF_FFFF;
  localparam logic [WordW-1:0] SampleCap  = 31'd2147483389;

  // bucket size is 2^31 / entries, so the index is a plain shift
  localparam longint BucketSize = 1 + (64'h7FFF_FFFE / TableEntries);
  localparam int     IdxShift   = $clog2(BucketSize);

  typedef logic [WordW-1:0] word_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [ProdW-1:0] prod_t;
  typedef logic [CntW-1:0]  cnt_t;

  // p mod (2^31 - 1): fold the high bits onto the low bits, one conditional subtract
  function automatic word_t mod_reduce(prod_t p);
    logic [WordW:0] s;
    s = {1'b0, p[WordW-1:0]} + (WordW+1)'(p[ProdW-1:WordW]);
    if (s >= {1'b0, LehmerMod}) begin
      s = s - {1'b0, LehmerMod};
    end
    return s[WordW-1:0];
  endfunction

endpackage

// File: rtl/slrg_ram.sv
`timescale 1ns / 1ps
// slrg_ram: generic single write port, single read port ram with registered read
// no dependencies
module slrg_ram #(
  parameter int DataWidth = 31,
  parameter int Depth     = 32
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(Depth)-1:0]     waddr_i,
  input  logic [DataWidth-1:0]         wdata_i,
  input  logic                         re_i,
  input  logic [$clog2(Depth)-1:0]     raddr_i,
  output logic [DataWidth-1:0]         rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/shuffled_lehmer_random_generator_core.sv
`timescale 1ns / 1ps
// shuffled_lehmer_random_generator_core: minimal-standard lehmer generator with a
// bays-durham shuffle table held in a synchronous ram; uses slrg_pkg and slrg_ram
//
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+---------------------------
// request  | in        | in_valid_i / in_ready_o    | command_i (1b), seed_i (31b)
// result   | out       | out_valid_o / out_ready_i  | sample_o (31b)
//
// a plain draw reads the entry picked by the last output and forms x * 16807,
// then reduces mod 2^31-1 and writes the entry back
// a reseed (or the first draw after reset) loads the start value, then runs
// TableEntries + 8 warm-up steps of StSeedMul and StSeedRed, then the plain draw
// reset clears the generator state and last output; seeding fills the whole table
// requests are taken while a result waits; a draw stalls at write-back until it drains
module shuffled_lehmer_random_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [30:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [30:0] sample_o
);

  // sequencer states
  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StSeedMul = 3'd1;
  localparam logic [2:0] StSeedRed = 3'd2;
  localparam logic [2:0] StIssue   = 3'd3;
  localparam logic [2:0] StDraw    = 3'd4;

  logic [2:0]     state_q, state_d;
  slrg_pkg::word_t x_q, x_d;          // lehmer state
  slrg_pkg::word_t last_q, last_d;    // last output, zero means never seeded
  slrg_pkg::prod_t prod_q;            // registered x * 16807
  slrg_pkg::cnt_t  cnt_q, cnt_d;      // warm-up step counter, counts down
  slrg_pkg::idx_t  idx_q;             // table entry of the draw in flight
  logic           out_valid_q, out_valid_d;
  slrg_pkg::word_t sample_q, sample_d;

  logic           accept;
  logic           need_seed;
  logic           issue;              // table read and multiply for a draw
  logic           load_prod;
  logic           out_free;
  slrg_pkg::word_t x_red;
  slrg_pkg::word_t seed_start;
  slrg_pkg::word_t idx_wide;
  slrg_pkg::idx_t  idx_cur;
  slrg_pkg::word_t entry;

  logic           ram_we;
  slrg_pkg::idx_t  ram_waddr;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign need_seed  = command_i || (last_q == '0);
  assign issue      = (accept && !need_seed) || (state_q == StIssue);
  assign load_prod  = issue || (state_q == StSeedMul);
  assign out_free   = !out_valid_q || out_ready_i;

  // a seed of zero or equal to the modulus falls back to one
  assign seed_start = (command_i && (seed_i != '0) && (seed_i != slrg_pkg::LehmerMod))
                      ? seed_i : slrg_pkg::WordW'(1);

  assign x_red = slrg_pkg::mod_reduce(prod_q);

  // bucket index from the last output, clamped to the top entry
  assign idx_wide = last_q >> slrg_pkg::IdxShift;
  assign idx_cur  = (idx_wide >= slrg_pkg::WordW'(slrg_pkg::TableEntries))
                    ? slrg_pkg::IdxW'(slrg_pkg::TableEntries - 1)
                    : idx_wide[slrg_pkg::IdxW-1:0];

  // warm-up writes fill entries from the top down; a draw writes back its entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    case (state_q)
      StSeedRed: begin
        ram_we    = (cnt_q < slrg_pkg::CntW'(slrg_pkg::TableEntries));
        ram_waddr = cnt_q[slrg_pkg::IdxW-1:0];
      end
      StDraw: begin
        ram_we    = out_free;
        ram_waddr = idx_q;
      end
      default: begin
        ram_we    = 1'b0;
        ram_waddr = idx_q;
      end
    endcase
  end

  slrg_ram #(
    .DataWidth (slrg_pkg::WordW),
    .Depth     (slrg_pkg::TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (x_red),
    .re_i    (issue),
    .raddr_i (idx_cur),
    .rdata_o (entry)
  );

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sample_d    = sample_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (need_seed) begin
            x_d     = seed_start;
            cnt_d   = slrg_pkg::CntW'(slrg_pkg::SeedSteps - 1);
            state_d = StSeedMul;
          end else begin
            state_d = StDraw;
          end
        end
      end
      StSeedMul: begin
        state_d = StSeedRed;
      end
      StSeedRed: begin
        x_d = x_red;
        if (cnt_q == '0) begin
          // entry 0 was just written with this value
          last_d  = x_red;
          state_d = StIssue;
        end else begin
          cnt_d   = cnt_q - slrg_pkg::CntW'(1);
          state_d = StSeedMul;
        end
      end
      StIssue: begin
        state_d = StDraw;
      end
      StDraw: begin
        // wait here with the read data held until the output register frees up
        if (out_free) begin
          x_d         = x_red;
          last_d      = entry;
          out_valid_d = 1'b1;
          sample_d    = (entry > slrg_pkg::SampleCap) ? slrg_pkg::SampleCap : entry;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      x_q         <= '0;
      last_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    if (load_prod) begin
      prod_q <= slrg_pkg::ProdW'(x_q) * slrg_pkg::ProdW'(slrg_pkg::LehmerMult);
    end
    if (issue) begin
      idx_q <= idx_cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  // the table is never written while waiting for a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !ram_we)
    else $error("table write outside a draw or warm-up");

  // a draw is only issued once the generator has been seeded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIssue) |-> (last_q != '0) && (x_q != '0))
    else $error("draw issued from an unseeded generator");

  // the lehmer state never reaches the modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_q != slrg_pkg::LehmerMod)
    else $error("lehmer state out of range");

  // a result enters the output register exactly when a draw completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDraw) && out_free |=> out_valid_q && (state_q == StIdle))
    else $error("completed draw did not produce a result");

endmodule

// File: tb/sv/slrg_tb_pkg.sv
`timescale 1ns / 1ps
// slrg_tb_pkg: request command codes shared by the generator testbench files
// no dependencies; used by slrg_checker and tb_shuffled_lehmer_random_generator_core
package slrg_tb_pkg;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_RESEED = 1'b1
  } slrg_cmd_e;

endpackage

// File: tb/sv/slrg_checker.sv
`timescale 1ns / 1ps
// slrg_checker: watches the request and result channels, predicts each sample
// and compares it in order; depends on slrg_pkg and slrg_tb_pkg
module slrg_checker
  import slrg_pkg::*;
  import slrg_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        command_i,
  input  logic [30:0] seed_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [30:0] sample_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam longint unsigned Modulus    = 64'd2147483647;
  localparam longint unsigned Multiplier = 64'd16807;
  localparam longint unsigned BucketSpan = 64'd1 + (Modulus - 64'd1) / TableEntries;
  localparam word_t           SampleMax  = 31'd2147483389;

  word_t gen_state;
  word_t prev_sample;
  word_t shuffle_q [TableEntries];
  word_t expected_samples [$];
  int    mismatches;

  function automatic word_t lehmer_next(word_t x);
    return word_t'((64'(x) * Multiplier) % Modulus);
  endfunction

  // advances the shadow generator by one request and returns its sample
  function automatic word_t next_sample(logic cmd, word_t seed_val);
    word_t x;
    longint unsigned slot;
    word_t picked;
    if (cmd == CMD_RESEED || prev_sample == '0) begin
      // zero and the modulus itself both fall back to a start of one
      x = (cmd == CMD_RESEED && seed_val != '0 && seed_val < LehmerMod) ? seed_val
                                                                        : word_t'(1);
      for (int n = SeedSteps - 1; n >= 0; n--) begin
        x = lehmer_next(x);
        if (n < TableEntries) begin
          shuffle_q[n] = x;
        end
      end
      gen_state   = x;
      prev_sample = shuffle_q[0];
    end
    gen_state = lehmer_next(gen_state);
    slot      = prev_sample / BucketSpan;
    if (slot >= TableEntries) begin
      slot = TableEntries - 1;
    end
    picked          = shuffle_q[slot];
    shuffle_q[slot] = gen_state;
    prev_sample     = picked;
    return (picked > SampleMax) ? SampleMax : picked;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_t want;
    if (!rst_ni) begin
      gen_state   = '0;
      prev_sample = '0;
      expected_samples.delete();
      mismatches  = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_samples.push_back(next_sample(command_i, seed_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result: sample %0d with no request pending", sample_i);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          if (sample_i !== want) begin
            $error("sample mismatch: expected %0d, actual %0d", want, sample_i);
            mismatches++;
          end
        end
      end
    end
    fail_count_o = mismatches;
    pending_o    = expected_samples.size();
  end

endmodule

// File: tb/sv/tb_shuffled_lehmer_random_generator_core.sv
`timescale 1ns / 1ps
// tb_shuffled_lehmer_random_generator_core: drives requests into the generator core,
// throttles the result side and reports the verdict; uses slrg_checker and both packages
module tb_shuffled_lehmer_random_generator_core;
  import slrg_pkg::*;
  import slrg_tb_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 9;
  localparam int IdlePercent   = 34;
  localparam int RandomItems   = 1000;
  localparam int QuietItems    = 150;   // opening stretch of the random part with no idling
  localparam int HoldAtItem    = 300;   // request index at which the sink backs off
  localparam int HoldOffCycles = 300;
  localparam int ReseedPercent = 8;
  // the limit covers every request being a reseed
  // with both sides stalling, several times over
  localparam int CycleLimit    = 400000;
  localparam int DrainCycles   = 200;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  logic  command;
  word_t seed;
  logic  out_valid;
  logic  out_ready;
  word_t sample;
  logic  quiet;      // both sides run without idling while set
  logic  hold_req;   // asks the sink for its long back-off
  int    fail_count;
  int    pending;
  int    cycle_count;

  initial clk = 1'b0;
  always #(ClkPeriod / 2) clk = ~clk;

  shuffled_lehmer_random_generator_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .command_i   (command),
    .seed_i      (seed),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .sample_o    (sample)
  );

  slrg_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .command_i    (command),
    .seed_i       (seed),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .sample_i     (sample),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // offer one request from a falling edge and return on the falling edge after
  // it is taken; valid is only dropped when an idle gap is chosen, so a
  // back-to-back request never sees valid lowered and raised in one step
  task automatic send_request(input slrg_cmd_e cmd, input word_t seed_val);
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    seed     <= seed_val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // request source: directed corner cases, then random traffic
  initial begin : request_source
    slrg_cmd_e rand_cmd;
    word_t     rand_seed;
    int        pick;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    command  = CMD_DRAW;
    seed     = '0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // draw with no seeding yet: the core seeds itself with one; seed field is ignored
    send_request(CMD_DRAW, 31'h7FFF_FFFF);
    send_request(CMD_DRAW, 31'h0000_0000);
    send_request(CMD_DRAW, 31'h2AAA_AAAA);
    // zero seed behaves as one
    send_request(CMD_RESEED, 31'd0);
    send_request(CMD_DRAW, 31'd0);
    // seed equal to the modulus also behaves as one
    send_request(CMD_RESEED, 31'h7FFF_FFFF);
    send_request(CMD_DRAW, 31'h5555_5555);
    send_request(CMD_RESEED, 31'd1);
    send_request(CMD_DRAW, 31'd1);
    // largest legal seed
    send_request(CMD_RESEED, 31'd2147483646);
    send_request(CMD_DRAW, 31'd0);
    send_request(CMD_DRAW, 31'd0);
    // alternating bit patterns and small seeds
    send_request(CMD_RESEED, 31'h2AAA_AAAA);
    send_request(CMD_RESEED, 31'h5555_5555);
    send_request(CMD_DRAW, 31'h7FFF_FFFF);
    send_request(CMD_RESEED, 31'd16807);
    send_request(CMD_RESEED, 31'd2);
    // reseeding twice with the same seed must repeat the sequence
    send_request(CMD_RESEED, 31'd12345);
    send_request(CMD_DRAW, 31'd0);
    send_request(CMD_RESEED, 31'd12345);
    send_request(CMD_DRAW, 31'd0);
    send_request(CMD_DRAW, 31'd0);

    for (int i = 0; i < RandomItems; i++) begin
      quiet <= (i < QuietItems);
      if (i == HoldAtItem) begin
        hold_req <= 1'b1;
      end
      pick     = $urandom_range(15);
      rand_cmd = ($urandom_range(99) < ReseedPercent) ? CMD_RESEED : CMD_DRAW;
      case (pick)
        0:       rand_seed = 31'd0;
        1:       rand_seed = 31'd1;
        2:       rand_seed = 31'h7FFF_FFFF;
        3:       rand_seed = 31'h7FFF_FFFE;
        default: rand_seed = word_t'($urandom());
      endcase
      send_request(rand_cmd, rand_seed);
    end
    in_valid <= 1'b0;

    // drain: every predicted sample out, then a margin of a full reseed and more
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("shuffled_lehmer_random_generator_core regression: pass");
    end else begin
      $display("shuffled_lehmer_random_generator_core regression: fail");
    end
    $finish;
  end

  // result sink: random back-pressure, one long back-off that lets the
  // core fill up and stall its request side, and no idling in the quiet stretch
  initial begin : result_sink
    int hold_cycles;
    hold_cycles = 0;
    out_ready   = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && hold_cycles < HoldOffCycles) begin
        hold_cycles++;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // watchdog on a cycle count
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("shuffled_lehmer_random_generator_core regression: fail");
    $finish;
  end

endmodule

// File: files.f
rtl/slrg_pkg.sv
rtl/slrg_ram.sv
rtl/shuffled_lehmer_random_generator_core.sv
tb/sv/slrg_tb_pkg.sv
tb/sv/slrg_checker.sv
tb/sv/tb_shuffled_lehmer_random_generator_core.sv
